### hdl/poc_pkg.sv
// Shared types and constants for the permutation order crossover block.
// Used by poc_seq, poc_emit, permutation_order_crossover and its testbench.
package poc_pkg;

  localparam int GENE_W = 6;
  localparam int POS_W = 6;
  localparam int NUM_W = 7;
  localparam int GENE_SPACE = 1 << GENE_W;
  localparam int MAX_GENES_DEFAULT = 64;
  localparam int NUM_GENES_MIN = 3;
  localparam logic [NUM_W-1:0] NUM_GENES_RESET = 7'd32;

  typedef enum logic [1:0] {
    KIND_LOAD_FIRST  = 2'd0,
    KIND_LOAD_SECOND = 2'd1,
    KIND_COMPUTE     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_HEAD,
    PH_TAIL
  } phase_t;

  // Control word that travels with a parent read to the data stage.
  typedef struct packed {
    logic   valid;
    phase_t op;
    logic   fin;
  } tag_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  position;
    logic [GENE_W-1:0] gene;
    logic [POS_W-1:0]  cut;
  } item_t;

  typedef struct packed {
    logic [GENE_W-1:0] child_gene;
    logic              last;
  } result_t;

endpackage

### hdl/permutation_order_crossover.sv
// Top level of the one-point order crossover block.
// Depends on poc_pkg, poc_ram, poc_seq and poc_emit.
//
// Usage:
//   item / item_valid / item_stall carry one input item. Kind load first or
//   load second writes one gene of a parent at the given position.
//   Kind compute emits the child route on result / result_valid /
//   result_stall, one gene per transfer, last set on the final gene.
//   cfg_valid / cfg_ready / cfg_data write the gene count n (saturated to
//   3..MAX_GENES); write it only while the block is idle.
// Operation:
//   Loads are accepted back to back. A compute holds item_stall through its
//   walk: n - cut reads of the first parent to set tail marks,
//   cut reads to emit the head, n reads of the second parent for the tail,
//   plus the registered read and the final flush. Each parent memory has a
//   single read port, so the reads are issued one at a time.
// Reset clears the gene count to 32, the tail marks and all control state;
// parent memories keep their contents. While result_valid and result_stall
// are both high the whole read pipeline holds and the result keeps its gene.
module permutation_order_crossover #(
  parameter int MAX_GENES = poc_pkg::MAX_GENES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  poc_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output poc_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [poc_pkg::NUM_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_GENES + 1);
  localparam int AW = $clog2(MAX_GENES);
  localparam logic [poc_pkg::NUM_W-1:0] MAX7 = poc_pkg::NUM_W'(MAX_GENES);
  localparam logic [poc_pkg::NUM_W-1:0] MIN7 = poc_pkg::NUM_W'(poc_pkg::NUM_GENES_MIN);

  logic [poc_pkg::NUM_W-1:0]  num_genes;
  logic [poc_pkg::NUM_W-1:0]  genes_sat;
  logic [poc_pkg::NUM_W-1:0]  cut_lim;
  logic [poc_pkg::NUM_W-1:0]  cut_wide;
  logic [poc_pkg::NUM_W-1:0]  cut_sat;
  logic                       accept;
  logic                       start;
  logic                       pos_ok;
  logic                       fp_we;
  logic                       sp_we;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [poc_pkg::GENE_W-1:0] fp_data;
  logic [poc_pkg::GENE_W-1:0] sp_data;
  poc_pkg::tag_t              tag;
  logic [CW-1:0]              genes;
  logic                       busy;
  logic                       adv;
  logic                       pend_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_genes <= poc_pkg::NUM_GENES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_genes <= cfg_data;
    end
  end

  always_comb begin
    if (num_genes < MIN7) begin
      genes_sat = MIN7;
    end else if (num_genes > MAX7) begin
      genes_sat = MAX7;
    end else begin
      genes_sat = num_genes;
    end
    cut_lim = genes_sat - poc_pkg::NUM_W'(2);
    cut_wide = {1'b0, item.cut};
    if (cut_wide < poc_pkg::NUM_W'(1)) begin
      cut_sat = poc_pkg::NUM_W'(1);
    end else if (cut_wide > cut_lim) begin
      cut_sat = cut_lim;
    end else begin
      cut_sat = cut_wide;
    end
  end

  // stay stalled until the last child gene has left the pending stage
  assign item_stall = busy || tag.valid || pend_valid;
  assign accept = item_valid && !item_stall;
  assign start = accept && (item.kind == poc_pkg::KIND_COMPUTE);
  assign pos_ok = {1'b0, item.position} < MAX7;
  assign fp_we = accept && pos_ok && (item.kind == poc_pkg::KIND_LOAD_FIRST);
  assign sp_we = accept && pos_ok && (item.kind == poc_pkg::KIND_LOAD_SECOND);

  poc_ram #(
    .WIDTH(poc_pkg::GENE_W),
    .DEPTH(MAX_GENES)
  ) u_first_parent (
    .clk  (clk),
    .we   (fp_we),
    .waddr(item.position[AW-1:0]),
    .wdata(item.gene),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(fp_data)
  );

  poc_ram #(
    .WIDTH(poc_pkg::GENE_W),
    .DEPTH(MAX_GENES)
  ) u_second_parent (
    .clk  (clk),
    .we   (sp_we),
    .waddr(item.position[AW-1:0]),
    .wdata(item.gene),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(sp_data)
  );

  poc_seq #(
    .MAX_GENES(MAX_GENES)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .genes_in(genes_sat[CW-1:0]),
    .cut_in  (cut_sat[CW-1:0]),
    .adv     (adv),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .tag     (tag),
    .genes   (genes),
    .busy    (busy)
  );

  poc_emit #(
    .MAX_GENES(MAX_GENES)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .tag         (tag),
    .genes       (genes),
    .fp_data     (fp_data),
    .sp_data     (sp_data),
    .result_stall(result_stall),
    .adv         (adv),
    .pend_valid  (pend_valid),
    .result_valid(result_valid),
    .result      (result)
  );

  // a compute transfer must lock out further items on the next cycle
  a_compute_locks: assert property (@(posedge clk) disable iff (rst)
    start |=> item_stall)
    else $error("compute transfer did not stall the input");

  // parent memories are never written while a walk reads them
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (fp_we || sp_we) |-> (!busy && !tag.valid))
    else $error("parent write during a compute walk");

  // the final gene only leaves once the pending stage is empty
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last && !$past(result_valid && result.last)) |-> !pend_valid)
    else $error("last gene issued with a gene still pending");

endmodule

### hdl/poc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module poc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the read data while not enabled
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/poc_seq.sv
// Read sequencer: walks the parent memories in three passes per compute.
// Depends on poc_pkg.
module poc_seq #(
  parameter int MAX_GENES = poc_pkg::MAX_GENES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [$clog2(MAX_GENES+1)-1:0]   genes_in,
  input  logic [$clog2(MAX_GENES+1)-1:0]   cut_in,
  input  logic                             adv,
  output logic                             rd_en,
  output logic [$clog2(MAX_GENES)-1:0]     rd_addr,
  output poc_pkg::tag_t                    tag,
  output logic [$clog2(MAX_GENES+1)-1:0]   genes,
  output logic                             busy
);

  localparam int CW = $clog2(MAX_GENES + 1);
  localparam int AW = $clog2(MAX_GENES);

  poc_pkg::phase_t state, state_next;
  poc_pkg::tag_t   tag_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   cut_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= poc_pkg::PH_IDLE;
      tag <= '{valid: 1'b0, op: poc_pkg::PH_IDLE, fin: 1'b0};
      idx <= '0;
    end else begin
      state <= state_next;
      tag <= tag_next;
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      genes <= genes_in;
      cut_point <= cut_in;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    rd_en = 1'b0;
    tag_next = tag;
    if (adv) begin
      tag_next = '{valid: 1'b0, op: poc_pkg::PH_IDLE, fin: 1'b0};
    end
    unique case (state)
      poc_pkg::PH_IDLE: begin
        if (start) begin
          state_next = poc_pkg::PH_MARK;
          idx_next = cut_in;
        end
      end
      poc_pkg::PH_MARK: begin
        if (adv) begin
          rd_en = 1'b1;
          tag_next = '{valid: 1'b1, op: poc_pkg::PH_MARK, fin: 1'b0};
          if (idx == genes - CW'(1)) begin
            state_next = poc_pkg::PH_HEAD;
            idx_next = '0;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end
      poc_pkg::PH_HEAD: begin
        if (adv) begin
          rd_en = 1'b1;
          tag_next = '{valid: 1'b1, op: poc_pkg::PH_HEAD, fin: 1'b0};
          if (idx == cut_point - CW'(1)) begin
            state_next = poc_pkg::PH_TAIL;
            idx_next = '0;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end
      poc_pkg::PH_TAIL: begin
        if (adv) begin
          rd_en = 1'b1;
          tag_next = '{valid: 1'b1, op: poc_pkg::PH_TAIL, fin: (idx == genes - CW'(1))};
          if (idx == genes - CW'(1)) begin
            state_next = poc_pkg::PH_IDLE;
            idx_next = '0;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end
      default: begin
        state_next = poc_pkg::PH_IDLE;
      end
    endcase
  end

  assign rd_addr = idx[AW-1:0];
  assign busy = (state != poc_pkg::PH_IDLE);

endmodule

### hdl/poc_emit.sv
// Data stage: tail mark vector, pending child gene and result register.
// Depends on poc_pkg.
module poc_emit #(
  parameter int MAX_GENES = poc_pkg::MAX_GENES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  poc_pkg::tag_t                       tag,
  input  logic [$clog2(MAX_GENES+1)-1:0]      genes,
  input  logic [poc_pkg::GENE_W-1:0]          fp_data,
  input  logic [poc_pkg::GENE_W-1:0]          sp_data,
  input  logic                                result_stall,
  output logic                                adv,
  output logic                                pend_valid,
  output logic                                result_valid,
  output poc_pkg::result_t                    result
);

  localparam int CW = $clog2(MAX_GENES + 1);

  logic [poc_pkg::GENE_SPACE-1:0] marks;
  logic [CW-1:0]                  count;
  logic [poc_pkg::GENE_W-1:0]     pend_gene;
  logic                           pend_done;
  logic                           emit_en;
  logic [poc_pkg::GENE_W-1:0]     emit_gene;
  logic                           load_mid;
  logic                           load_fin;
  logic                           fin_now;

  assign adv = !result_valid || !result_stall;
  assign fin_now = tag.valid && tag.fin;

  always_comb begin
    emit_en = 1'b0;
    emit_gene = fp_data;
    case (tag.op)
      poc_pkg::PH_HEAD: begin
        emit_en = tag.valid;
      end
      poc_pkg::PH_TAIL: begin
        emit_en = tag.valid && marks[sp_data] && (count < genes);
        emit_gene = sp_data;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // older pending gene moves out when a newer one arrives; the final one
  // goes out with last set once the second-parent walk has ended
  assign load_mid = adv && emit_en && pend_valid;
  assign load_fin = adv && pend_done && !fin_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
      count <= '0;
      pend_valid <= 1'b0;
      pend_done <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (start) begin
        marks <= '0;
        count <= '0;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (adv && tag.valid && tag.op == poc_pkg::PH_MARK) begin
        marks[fp_data] <= 1'b1;
      end
      if (adv && emit_en) begin
        count <= count + CW'(1);
        pend_valid <= 1'b1;
      end
      if (load_mid) begin
        result_valid <= 1'b1;
      end
      if (adv && fin_now) begin
        pend_done <= 1'b1;
      end else if (load_fin) begin
        result_valid <= 1'b1;
        pend_valid <= 1'b0;
        pend_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_en) begin
      pend_gene <= emit_gene;
    end
    if (load_mid) begin
      result <= '{child_gene: pend_gene, last: 1'b0};
    end else if (load_fin) begin
      result <= '{child_gene: pend_gene, last: 1'b1};
    end
  end

endmodule

### test/permutation_order_crossover_tb.sv
// Self-checking testbench for permutation_order_crossover: loads parent routes,
// issues crossovers and compares each child gene against a behavioral model.
// Depends on poc_pkg and the permutation_order_crossover RTL.
`timescale 1ns / 1ps

class route_scoreboard;
  logic [poc_pkg::GENE_W-1:0] first_genes[poc_pkg::MAX_GENES_DEFAULT];
  logic [poc_pkg::GENE_W-1:0] second_genes[poc_pkg::MAX_GENES_DEFAULT];
  logic [poc_pkg::NUM_W-1:0]  gene_count;
  poc_pkg::result_t           expected_genes[$];
  int                         errors;

  function new();
    gene_count = poc_pkg::NUM_GENES_RESET;
    errors = 0;
  endfunction

  function void write_count(logic [poc_pkg::NUM_W-1:0] value);
    gene_count = value;
  endfunction

  function int unsigned route_len();
    int unsigned n;
    n = gene_count;
    if (n < poc_pkg::NUM_GENES_MIN) n = poc_pkg::NUM_GENES_MIN;
    if (n > poc_pkg::MAX_GENES_DEFAULT) n = poc_pkg::MAX_GENES_DEFAULT;
    return n;
  endfunction

  function int pending();
    return expected_genes.size();
  endfunction

  // Update the parent stores or queue the child route of one accepted item.
  function void apply_item(poc_pkg::item_t it);
    int unsigned      n;
    int unsigned      cut_pt;
    int unsigned      emitted;
    bit               marks[poc_pkg::GENE_SPACE];
    poc_pkg::result_t r;
    case (it.kind)
      poc_pkg::KIND_LOAD_FIRST: begin
        first_genes[it.position] = it.gene;
      end
      poc_pkg::KIND_LOAD_SECOND: begin
        second_genes[it.position] = it.gene;
      end
      poc_pkg::KIND_COMPUTE: begin
        n = route_len();
        cut_pt = it.cut;
        if (cut_pt < 1) cut_pt = 1;
        if (cut_pt > n - 2) cut_pt = n - 2;
        foreach (marks[g]) marks[g] = 1'b0;
        for (int unsigned i = cut_pt; i < n; i++) marks[first_genes[i]] = 1'b1;
        emitted = 0;
        for (int unsigned i = 0; i < cut_pt; i++) begin
          r.child_gene = first_genes[i];
          r.last = 1'b0;
          expected_genes.push_back(r);
          emitted++;
        end
        // Walk the second parent once; stop as soon as the route is full.
        for (int unsigned i = 0; i < n && emitted < n; i++) begin
          if (marks[second_genes[i]]) begin
            r.child_gene = second_genes[i];
            r.last = 1'b0;
            expected_genes.push_back(r);
            emitted++;
          end
        end
        r = expected_genes.pop_back();
        r.last = 1'b1;
        expected_genes.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_gene(poc_pkg::result_t got);
    poc_pkg::result_t exp;
    if (expected_genes.size() == 0) begin
      $error("unexpected child gene %0d (last %0d)", got.child_gene, got.last);
      errors++;
    end else begin
      exp = expected_genes.pop_front();
      if (got.child_gene !== exp.child_gene) begin
        $error("child_gene mismatch: expected %0d, got %0d", exp.child_gene, got.child_gene);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last mismatch: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    end
  endfunction
endclass

module permutation_order_crossover_tb;
  import poc_pkg::*;

  localparam int MAX_GENES = MAX_GENES_DEFAULT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 230;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [NUM_W-1:0] cfg_data;

  route_scoreboard sb;
  int unsigned     items_sent;
  int unsigned     burst_left;
  int unsigned     loaded_n;
  bit              route_ok;
  int unsigned     idle_cycles;
  int unsigned     stall_mode;
  int unsigned     stall_mode_left;
  int unsigned     stall_run;

  permutation_order_crossover #(
    .MAX_GENES(MAX_GENES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver stall pattern: switch between no stall, light, heavy and toggling.
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(20, 200);
    end
    stall_mode_left--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_run < 6 && $urandom_range(0, 3) != 0) begin
          result_stall <= 1'b1;
          stall_run++;
        end else begin
          result_stall <= 1'b0;
          stall_run = 0;
        end
      end
      default: result_stall <= ~result_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_gene(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic item_t make_load(kind_t k, int unsigned pos, int unsigned g);
    item_t it;
    it.kind = k;
    it.position = pos;
    it.gene = g;
    it.cut = $urandom_range(0, 63);
    return it;
  endfunction

  function automatic void shuffle_genes(ref logic [GENE_W-1:0] a[MAX_GENES],
                                        input int unsigned n);
    int unsigned         j;
    logic [GENE_W-1:0]   tmp;
    for (int unsigned i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = a[i];
      a[i] = a[j];
      a[j] = tmp;
    end
  endfunction

  // Drive one item in bursts with random gaps, hold it until the transfer.
  task automatic send(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.apply_item(it);
    if (it.kind != kind_t'(KIND_UNUSED)) items_sent++;
  endtask

  task automatic compute(input int unsigned cut_pt);
    item_t it;
    it.kind = KIND_COMPUTE;
    it.position = $urandom_range(0, 63);
    it.gene = $urandom_range(0, 63);
    it.cut = cut_pt;
    send(it);
  endtask

  task automatic send_unused();
    item_t it;
    it.kind = kind_t'(KIND_UNUSED);
    it.position = $urandom_range(0, 63);
    it.gene = $urandom_range(0, 63);
    it.cut = $urandom_range(0, 63);
    send(it);
  endtask

  // Now and then slip in an ignored kind or a load beyond the active route.
  task automatic maybe_noise(input int unsigned n);
    if ($urandom_range(0, 11) == 0) begin
      if (n >= MAX_GENES || $urandom_range(0, 1) == 0) begin
        send_unused();
      end else begin
        send(make_load($urandom_range(0, 1) ? KIND_LOAD_SECOND : KIND_LOAD_FIRST,
                       $urandom_range(n, MAX_GENES - 1), $urandom_range(0, 63)));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_count(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load two permutations of the same random gene set in a shuffled order.
  task automatic full_load(input int unsigned n);
    logic [GENE_W-1:0] pool[MAX_GENES];
    logic [GENE_W-1:0] other[MAX_GENES];
    item_t             loads[$];
    item_t             tmp;
    int unsigned       j;
    for (int unsigned i = 0; i < MAX_GENES; i++) pool[i] = i;
    shuffle_genes(pool, MAX_GENES);
    other = pool;
    shuffle_genes(other, n);
    for (int unsigned i = 0; i < n; i++) begin
      loads.push_back(make_load(KIND_LOAD_FIRST, i, pool[i]));
      loads.push_back(make_load(KIND_LOAD_SECOND, i, other[i]));
    end
    for (int unsigned i = loads.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = loads[i];
      loads[i] = loads[j];
      loads[j] = tmp;
    end
    foreach (loads[i]) begin
      maybe_noise(n);
      send(loads[i]);
    end
    loaded_n = n;
    route_ok = 1'b1;
  endtask

  // Swap gene pairs inside a parent; occasionally break the permutation.
  task automatic mutate(input int unsigned n);
    int unsigned       i;
    int unsigned       j;
    logic [GENE_W-1:0] gi;
    logic [GENE_W-1:0] gj;
    bit                use_second;
    repeat ($urandom_range(1, 2)) begin
      use_second = $urandom_range(0, 1);
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      gi = use_second ? sb.second_genes[i] : sb.first_genes[i];
      gj = use_second ? sb.second_genes[j] : sb.first_genes[j];
      send(make_load(use_second ? KIND_LOAD_SECOND : KIND_LOAD_FIRST, i, gj));
      send(make_load(use_second ? KIND_LOAD_SECOND : KIND_LOAD_FIRST, j, gi));
    end
    if ($urandom_range(0, 4) == 0) begin
      send(make_load($urandom_range(0, 1) ? KIND_LOAD_SECOND : KIND_LOAD_FIRST,
                     $urandom_range(0, n - 1), $urandom_range(0, 63)));
      route_ok = 1'b0;
    end
  endtask

  initial begin
    int unsigned seq;
    int unsigned n;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    stall_mode = 0;
    stall_mode_left = 0;
    stall_run = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: smallest route, field extremes, saturated cuts and counts.
    write_count(3);
    send(make_load(KIND_LOAD_FIRST, 0, 63));
    send(make_load(KIND_LOAD_FIRST, 1, 0));
    send(make_load(KIND_LOAD_FIRST, 2, 17));
    send(make_load(KIND_LOAD_SECOND, 0, 17));
    send(make_load(KIND_LOAD_SECOND, 1, 63));
    send(make_load(KIND_LOAD_SECOND, 2, 0));
    send(make_load(KIND_LOAD_FIRST, 63, 63));
    send(make_load(KIND_LOAD_SECOND, 63, 0));
    compute(0);
    compute(63);
    compute(1);
    send_unused();
    // Repeated tail gene in the second parent: route is cut off at n genes.
    send(make_load(KIND_LOAD_SECOND, 1, 17));
    compute(1);
    // Tail gene missing from the second parent: route comes out short.
    send(make_load(KIND_LOAD_SECOND, 0, 63));
    send(make_load(KIND_LOAD_SECOND, 1, 63));
    compute(1);
    write_count(0);
    compute(5);
    write_count(2);
    compute(0);
    loaded_n = 3;
    route_ok = 1'b0;

    // Random: mostly well-formed permutations, a few breaks and noise.
    seq = 0;
    while (seq < 8 || items_sent < ITEM_TARGET) begin
      if (seq == 2) begin
        write_count(64);
      end else if (seq == 5) begin
        write_count(127);
      end else if (seq == 6 || (seq > 6 && $urandom_range(0, 2) == 0)) begin
        write_count($urandom_range(0, 16));
      end else if (seq % 4 == 3) begin
        drain();
      end
      n = sb.route_len();
      if (n != loaded_n || (n <= 16 && (!route_ok || $urandom_range(0, 3) == 0))) begin
        full_load(n);
      end else begin
        mutate(n);
      end
      repeat ($urandom_range(1, 3)) begin
        maybe_noise(n);
        case ($urandom_range(0, 7))
          0: compute(0);
          1: compute(1);
          2: compute(n - 2);
          3: compute(n - 1);
          4: compute(63);
          default: compute($urandom_range(0, 63));
        endcase
      end
      seq++;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
